// File: sv/cvkf_pkg.sv
package cvkf_pkg;

    localparam logic signed [31:0] Q_ONE     = 32'sd16777216;
    localparam logic signed [31:0] S32_MAX   = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN   = 32'sh80000000;
    localparam logic [30:0] NOISE_POS_RESET  = 31'd1678;
    localparam logic [30:0] NOISE_VEL_RESET  = 31'd16777;
    localparam logic [30:0] NOISE_MEAS_RESET = 31'd167772;

    // register indexes of the configuration port
    localparam logic [1:0] REG_NOISE_POS  = 2'd0;
    localparam logic [1:0] REG_NOISE_VEL  = 2'd1;
    localparam logic [1:0] REG_NOISE_MEAS = 2'd2;

    localparam int DIV_BITS = 56;   // dividend magnitude |num| * 2^24
    localparam int DIV_STEP = 2;    // quotient bits per cycle

    typedef struct packed {
        logic [2:0]         channel;
        logic [23:0]        time_step;
        logic signed [31:0] measured_position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         result_channel;
        logic signed [31:0] filtered_position;
        logic signed [31:0] velocity_estimate;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] p00;
        logic signed [31:0] p01;
        logic signed [31:0] p10;
        logic signed [31:0] p11;
    } t_chan_state;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_MUL, S_DSET, S_DIV, S_DFIN, S_WRITE
    } t_fsm;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'(S32_MAX)) return S32_MAX;
        if (v < 34'(S32_MIN)) return S32_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat32(34'(a) + 34'(b));
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat32(34'(a) - 34'(b));
    endfunction

    // signed magnitude back to a saturated 32-bit value
    function automatic logic signed [31:0] sat_mag(input logic [55:0] m, input logic neg);
        logic [31:0] t;
        t = m[31:0];
        if (neg) begin
            if (m > 56'h80000000) return S32_MIN;
            return $signed(~t + 32'd1);
        end
        if (m > 56'h7fffffff) return S32_MAX;
        return $signed(t);
    endfunction

    // q8.24 product back to q8.24, rounded half away from zero
    function automatic logic signed [31:0] mulq_round(input logic signed [63:0] p);
        logic [63:0] m;
        logic [63:0] r;
        m = p[63] ? 64'(-p) : 64'(p);
        r = (m + 64'd8388608) >> 24;
        return sat_mag(r[55:0], p[63]);
    endfunction

endpackage

// File: sv/constant_velocity_kalman_filter_unit.sv
// channel | direction | handshake        | payload
// in      | input     | valid / stall    | channel, time_step, measured_position
// out     | output    | valid / stall    | result_channel, filtered_position, velocity_estimate
// cfg     | input     | valid / ready    | register index, write data
// a started channel runs ten multiplies on one shared 32x32 multiplier, each product
// registered before it is accumulated, and one radix-4 divide for both gains
// a first sample or an out-of-range channel goes from accept straight to write-back
// one-port state memory, read into a register on accept; reset clears started bits, not memory
// the next item is taken while a result waits; output stall holds only the write-back step
module constant_velocity_kalman_filter_unit #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cvkf_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cvkf_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import cvkf_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DIV_CYCLES = DIV_BITS / DIV_STEP;

    t_chan_state r_mem [NUM_CHANNELS];
    t_chan_state r_rd;
    logic [NUM_CHANNELS-1:0] r_started;

    t_fsm r_state, n_state;
    logic [30:0] r_qpos, r_qvel, r_rnoise;

    logic [2:0]         r_ch;
    logic [AW-1:0]      r_addr;
    logic [23:0]        r_dt;
    logic signed [31:0] r_meas;
    logic               r_inrange;

    logic signed [31:0] r_pos, r_vel, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_posp, r_a00, r_a01, r_pp00, r_pp10, r_pp11;
    logic signed [31:0] r_y, r_k0, r_k1, r_onek0;
    logic signed [63:0] r_prod;
    logic [3:0]         r_step;
    logic               r_phase;

    logic [31:0]         r_den;
    logic                r_den_zero, r_dneg0, r_dneg1, r_nneg0, r_nneg1, r_nz0, r_nz1;
    logic [31:0]         r_rem0, r_rem1;
    logic [DIV_BITS-1:0] r_dvd0, r_dvd1;
    logic [4:0]          r_dcnt;

    logic in_accept, wr_go, in_range;
    logic [8:0] ch_ext;
    logic [AW-1:0] in_addr;
    logic signed [31:0] op_a, op_b, mq, s_val;
    logic [31:0] n_rem0, n_rem1;
    logic [DIV_BITS-1:0] n_dvd0, n_dvd1;
    logic [32:0] sh0, sh1;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign ch_ext      = {6'd0, i_in_item.channel};
    assign in_range    = ch_ext < 9'(NUM_CHANNELS);
    assign in_addr     = ch_ext[AW-1:0];
    assign o_cfg_ready = 1'b1;
    assign mq          = mulq_round(r_prod);
    assign s_val       = sat_add(r_pp00, $signed({1'b0, r_rnoise}));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_accept) n_state = (in_range && r_started[in_addr]) ? S_LOAD
                                                                               : S_WRITE;
            S_LOAD:  n_state = S_MUL;
            S_MUL: begin
                if (r_phase && r_step == 4'd3) n_state = S_DSET;
                else if (r_phase && r_step == 4'd9) n_state = S_WRITE;
            end
            S_DSET:  n_state = S_DIV;
            S_DIV:   if (r_dcnt == 5'(DIV_CYCLES - 1)) n_state = S_DFIN;
            S_DFIN:  n_state = S_MUL;
            S_WRITE: if (!o_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        wr_go      = (r_state == S_WRITE) && (!o_out_valid || !i_out_stall);
    end

    always_comb begin
        case (r_step)
            4'd0:    begin op_a = r_vel;   op_b = $signed({8'd0, r_dt}); end
            4'd1:    begin op_a = r_p10;   op_b = $signed({8'd0, r_dt}); end
            4'd2:    begin op_a = r_p11;   op_b = $signed({8'd0, r_dt}); end
            4'd3:    begin op_a = r_a01;   op_b = $signed({8'd0, r_dt}); end
            4'd4:    begin op_a = r_k0;    op_b = r_y;    end
            4'd5:    begin op_a = r_k1;    op_b = r_y;    end
            4'd6:    begin op_a = r_onek0; op_b = r_pp00; end
            4'd7:    begin op_a = r_onek0; op_b = r_a01;  end
            4'd8:    begin op_a = r_k1;    op_b = r_pp00; end
            default: begin op_a = r_k1;    op_b = r_a01;  end
        endcase
    end

    // two restoring-division steps per cycle for each gain
    always_comb begin
        n_rem0 = r_rem0;
        n_rem1 = r_rem1;
        n_dvd0 = r_dvd0;
        n_dvd1 = r_dvd1;
        sh0 = '0;
        sh1 = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            sh0 = {n_rem0, n_dvd0[DIV_BITS-1]};
            sh1 = {n_rem1, n_dvd1[DIV_BITS-1]};
            n_dvd0 = {n_dvd0[DIV_BITS-2:0], 1'b0};
            n_dvd1 = {n_dvd1[DIV_BITS-2:0], 1'b0};
            if (sh0 >= {1'b0, r_den}) begin
                sh0 = sh0 - {1'b0, r_den};
                n_dvd0[0] = 1'b1;
            end
            if (sh1 >= {1'b0, r_den}) begin
                sh1 = sh1 - {1'b0, r_den};
                n_dvd1[0] = 1'b1;
            end
            n_rem0 = sh0[31:0];
            n_rem1 = sh1[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= '0;
            o_out_valid <= 1'b0;
            r_qpos      <= NOISE_POS_RESET;
            r_qvel      <= NOISE_VEL_RESET;
            r_rnoise    <= NOISE_MEAS_RESET;
        end else begin
            r_state <= n_state;
            if (wr_go) begin
                o_out_valid <= 1'b1;
                if (r_inrange) r_started[r_addr] <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_NOISE_POS:  r_qpos   <= i_cfg_data[30:0];
                    REG_NOISE_VEL:  r_qvel   <= i_cfg_data[30:0];
                    REG_NOISE_MEAS: r_rnoise <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) r_rd <= r_mem[in_addr];
        if (wr_go && r_inrange)
            r_mem[r_addr] <= '{pos: r_pos, vel: r_vel, p00: r_p00, p01: r_p01,
                               p10: r_p10, p11: r_p11};
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch      <= i_in_item.channel;
            r_addr    <= in_addr;
            r_dt      <= i_in_item.time_step;
            r_meas    <= i_in_item.measured_position;
            r_inrange <= in_range;
            // first sample and out-of-range pass the measurement through
            r_pos     <= i_in_item.measured_position;
            r_vel     <= '0;
            r_p00     <= Q_ONE;
            r_p01     <= '0;
            r_p10     <= '0;
            r_p11     <= Q_ONE;
            r_step    <= '0;
            r_phase   <= 1'b0;
        end
        case (r_state)
            S_LOAD: begin
                r_pos <= r_rd.pos;
                r_vel <= r_rd.vel;
                r_p00 <= r_rd.p00;
                r_p01 <= r_rd.p01;
                r_p10 <= r_rd.p10;
                r_p11 <= r_rd.p11;
            end
            S_MUL: begin
                r_phase <= !r_phase;
                if (!r_phase) begin
                    r_prod <= op_a * op_b;
                end else begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd0: r_posp <= sat_add(r_pos, mq);
                        4'd1: r_a00  <= sat_add(r_p00, mq);
                        4'd2: begin
                            r_a01  <= sat_add(r_p01, mq);
                            r_pp10 <= sat_add(r_p10, mq);
                        end
                        4'd3: begin
                            r_pp00 <= sat_add(sat_add(r_a00, mq), $signed({1'b0, r_qpos}));
                            r_pp11 <= sat_add(r_p11, $signed({1'b0, r_qvel}));
                        end
                        4'd4: r_pos <= sat_add(r_posp, mq);
                        4'd5: r_vel <= sat_add(r_vel, mq);
                        4'd6: r_p00 <= mq;
                        4'd7: r_p01 <= mq;
                        4'd8: r_p10 <= sat_sub(r_pp10, mq);
                        4'd9: r_p11 <= sat_sub(r_pp11, mq);
                        default: ;
                    endcase
                end
            end
            S_DSET: begin
                r_y        <= sat_sub(r_meas, r_posp);
                r_den      <= s_val[31] ? 32'(-s_val) : 32'(s_val);
                r_den_zero <= (s_val == '0);
                r_dneg0    <= r_pp00[31] ^ s_val[31];
                r_dneg1    <= r_pp10[31] ^ s_val[31];
                r_nneg0    <= r_pp00[31];
                r_nneg1    <= r_pp10[31];
                r_nz0      <= (r_pp00 == '0);
                r_nz1      <= (r_pp10 == '0);
                r_dvd0     <= {(r_pp00[31] ? 32'(-r_pp00) : 32'(r_pp00)), 24'd0};
                r_dvd1     <= {(r_pp10[31] ? 32'(-r_pp10) : 32'(r_pp10)), 24'd0};
                r_rem0     <= '0;
                r_rem1     <= '0;
                r_dcnt     <= '0;
            end
            S_DIV: begin
                r_rem0 <= n_rem0;
                r_rem1 <= n_rem1;
                r_dvd0 <= n_dvd0;
                r_dvd1 <= n_dvd1;
                r_dcnt <= r_dcnt + 5'd1;
            end
            S_DFIN: begin
                // zero divisor: gain saturates by the numerator's sign, or is zero for a zero numerator
                if (r_den_zero) begin
                    r_k0    <= r_nz0 ? '0 : (r_nneg0 ? S32_MIN : S32_MAX);
                    r_k1    <= r_nz1 ? '0 : (r_nneg1 ? S32_MIN : S32_MAX);
                    r_onek0 <= sat_sub(Q_ONE,
                                       r_nz0 ? '0 : (r_nneg0 ? S32_MIN : S32_MAX));
                end else begin
                    r_k0    <= sat_mag(r_dvd0, r_dneg0);
                    r_k1    <= sat_mag(r_dvd1, r_dneg1);
                    r_onek0 <= sat_sub(Q_ONE, sat_mag(r_dvd0, r_dneg0));
                end
            end
            default: ;
        endcase
        if (wr_go) begin
            o_out_item.result_channel    <= r_ch;
            o_out_item.filtered_position <= r_pos;
            o_out_item.velocity_estimate <= r_vel;
        end
    end

endmodule

// File: sv/cvkf_checker.sv
module cvkf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input cvkf_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cvkf_pkg::t_out_item o_out_item,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [1:0]          i_cfg_index,
    input logic [31:0]         i_cfg_data
);
    import cvkf_pkg::*;

    // a waiting result is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // every item keeps the block busy for at least the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block idle right after accepting an item");

    // the block only turns busy when an item was taken
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("busy without an accepted item");

    // a new result only appears as the block goes idle
    a_out_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result raised while still busy");

endmodule

bind constant_velocity_kalman_filter_unit cvkf_checker u_cvkf_checker (.*);
